// ===== sv/wmm_pkg.sv =====
// Shared definitions for the window min/max/midpoint filter.
// Field widths, register codes, filter modes and the stage control bundle.
// No dependencies.
`default_nettype none

package wmm_pkg;

  // Field and register widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FRAME_W_W  = 11;
  localparam int unsigned FRAME_H_W  = 13;
  localparam int unsigned RADIUS_W   = 2;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Default sizing of the line memory and the window
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_RADIUS_DEF = 3;

  // Largest frame height the row counter serves
  localparam int unsigned HEIGHT_LIMIT = 4096;

  // Neutral element of the minimum search
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Register values after reset
  localparam logic [FRAME_W_W-1:0] WIDTH_RST  = 11'd512;
  localparam logic [FRAME_H_W-1:0] HEIGHT_RST = 13'd512;
  localparam logic [RADIUS_W-1:0]  RADIUS_RST = 2'd1;
  localparam logic [MODE_W-1:0]    MODE_RST   = 2'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_MODE   = 2'd3
  } cfg_reg_e;

  // Filter modes; the unused code acts as the midpoint
  typedef enum logic [MODE_W-1:0] {
    MODE_MIN = 2'd0,
    MODE_MAX = 2'd1,
    MODE_MID = 2'd2
  } mode_e;

  // Per-item control that travels down the pipeline
  typedef struct packed {
    logic              emit;
    logic              frame_end;
    logic [MODE_W-1:0] mode;
  } wmm_ctl_t;

endpackage

`default_nettype wire

// ===== sv/wmm_col_store.sv =====
// Column store of the window filter: line memory with one byte lane per row slot,
// and the vertical min/max over the rows of the window for the current column.
// Depends on wmm_pkg.
`default_nettype none

module wmm_col_store #(
  parameter int unsigned MAX_WIDTH  = wmm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_RADIUS = wmm_pkg::MAX_RADIUS_DEF,
  localparam int unsigned SLOTS  = 2 * MAX_RADIUS + 1,
  localparam int unsigned SLOT_W = $clog2(SLOTS),
  localparam int unsigned RAD_W  = $clog2(MAX_RADIUS + 1),
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // upstream item
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [wmm_pkg::PIX_W-1:0] pixel_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         addr_i,
  input  logic [SLOT_W-1:0]         slot_i,
  input  logic [SLOT_W-1:0]         row_small_i,
  input  logic [RAD_W-1:0]          row_excess_i,
  input  logic [SLOT_W-1:0]         span_i,
  input  logic [SLOT_W-1:0]         col_small_i,
  input  logic [RAD_W-1:0]          col_excess_i,
  input  wmm_pkg::wmm_ctl_t         ctl_i,
  // downstream item
  output logic                      valid_o,
  input  logic                      dn_ready_i,
  output logic [wmm_pkg::PIX_W-1:0] vmin_o,
  output logic [wmm_pkg::PIX_W-1:0] vmax_o,
  output logic [SLOT_W-1:0]         span_o,
  output logic [SLOT_W-1:0]         col_small_o,
  output logic [RAD_W-1:0]          col_excess_o,
  output wmm_pkg::wmm_ctl_t         ctl_o
);
  import wmm_pkg::*;

  logic [SLOTS*PIX_W-1:0] mem [MAX_WIDTH];
  logic [SLOTS*PIX_W-1:0] rd_q;

  logic              valid_q, valid_d;
  logic [PIX_W-1:0]  pix_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] row_small_q;
  logic [RAD_W-1:0]  row_excess_q;
  logic [SLOT_W-1:0] span_q;
  logic [SLOT_W-1:0] col_small_q;
  logic [RAD_W-1:0]  col_excess_q;
  wmm_ctl_t          ctl_q;
  logic              fire;

  assign in_ready_o = !valid_q || dn_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  // Write the new pixel into its row lane; read the column word of the same item
  always_ff @(posedge clk_i) begin
    if (fire && we_i) begin
      mem[addr_i][slot_i*PIX_W +: PIX_W] <= pixel_i;
    end
    if (fire) begin
      rd_q <= mem[addr_i];
    end
  end

  // Hold the item's payload beside the read data
  always_ff @(posedge clk_i) begin
    if (fire) begin
      pix_q        <= pixel_i;
      slot_q       <= slot_i;
      row_small_q  <= row_small_i;
      row_excess_q <= row_excess_i;
      span_q       <= span_i;
      col_small_q  <= col_small_i;
      col_excess_q <= col_excess_i;
      ctl_q        <= ctl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Vertical min/max over the row slots inside the window and the frame;
  // the current row's lane comes from the item itself
  always_comb begin
    logic [PIX_W-1:0]  px;
    logic [SLOT_W-1:0] lag;
    logic              incl;
    vmin_o = PIX_MAX;
    vmax_o = '0;
    for (int s = 0; s < int'(SLOTS); s++) begin
      px = (SLOT_W'(s) == slot_q) ? pix_q : rd_q[s*PIX_W +: PIX_W];
      if (SLOT_W'(s) <= slot_q) begin
        lag = slot_q - SLOT_W'(s);
      end else begin
        lag = SLOT_W'(int'(slot_q) + int'(SLOTS) - s);
      end
      incl = (lag <= span_q) && (lag <= row_small_q) && (lag >= SLOT_W'(row_excess_q));
      if (incl && (px < vmin_o)) begin
        vmin_o = px;
      end
      if (incl && (px > vmax_o)) begin
        vmax_o = px;
      end
    end
  end

  assign valid_o      = valid_q;
  assign span_o       = span_q;
  assign col_small_o  = col_small_q;
  assign col_excess_o = col_excess_q;
  assign ctl_o        = ctl_q;

`ifndef SYNTHESIS
  // A stalled column item keeps its place and its row slot
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !dn_ready_i |=> valid_q && $stable(slot_q) && $stable(ctl_q))
    else $error("column stage dropped or changed a stalled item");
`endif

endmodule

`default_nettype wire

// ===== sv/wmm_row_window.sv =====
// Row window of the filter: shift line of per-column min/max values and the
// horizontal reduction over the columns of the window inside the frame.
// Depends on wmm_pkg.
`default_nettype none

module wmm_row_window #(
  parameter int unsigned MAX_RADIUS = wmm_pkg::MAX_RADIUS_DEF,
  localparam int unsigned SLOTS  = 2 * MAX_RADIUS + 1,
  localparam int unsigned SLOT_W = $clog2(SLOTS),
  localparam int unsigned RAD_W  = $clog2(MAX_RADIUS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // upstream item
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [wmm_pkg::PIX_W-1:0] vmin_i,
  input  logic [wmm_pkg::PIX_W-1:0] vmax_i,
  input  logic [SLOT_W-1:0]         span_i,
  input  logic [SLOT_W-1:0]         col_small_i,
  input  logic [RAD_W-1:0]          col_excess_i,
  input  wmm_pkg::wmm_ctl_t         ctl_i,
  // downstream item
  output logic                      valid_o,
  input  logic                      dn_ready_i,
  output logic [wmm_pkg::PIX_W-1:0] lo_o,
  output logic [wmm_pkg::PIX_W-1:0] hi_o,
  output wmm_pkg::wmm_ctl_t         ctl_o
);
  import wmm_pkg::*;

  logic              valid_q, valid_d;
  logic [PIX_W-1:0]  hmin_q [SLOTS];
  logic [PIX_W-1:0]  hmax_q [SLOTS];
  logic [SLOT_W-1:0] span_q;
  logic [SLOT_W-1:0] col_small_q;
  logic [RAD_W-1:0]  col_excess_q;
  wmm_ctl_t          ctl_q;
  logic              load;

  assign ready_o = !valid_q || dn_ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  // Advance the column line by one column per item
  always_ff @(posedge clk_i) begin
    if (load) begin
      hmin_q[0] <= vmin_i;
      hmax_q[0] <= vmax_i;
      for (int j = 1; j < int'(SLOTS); j++) begin
        hmin_q[j] <= hmin_q[j-1];
        hmax_q[j] <= hmax_q[j-1];
      end
      span_q       <= span_i;
      col_small_q  <= col_small_i;
      col_excess_q <= col_excess_i;
      ctl_q        <= ctl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Horizontal min/max; tap j holds the column j places to the left
  always_comb begin
    logic incl;
    lo_o = PIX_MAX;
    hi_o = '0;
    for (int j = 0; j < int'(SLOTS); j++) begin
      incl = (SLOT_W'(j) <= span_q) && (SLOT_W'(j) <= col_small_q) &&
             (SLOT_W'(j) >= SLOT_W'(col_excess_q));
      if (incl && (hmin_q[j] < lo_o)) begin
        lo_o = hmin_q[j];
      end
      if (incl && (hmax_q[j] > hi_o)) begin
        hi_o = hmax_q[j];
      end
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;

`ifndef SYNTHESIS
  // Every result window holds its own center, so the bounds never cross
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ctl_q.emit |-> lo_o <= hi_o)
    else $error("window minimum above window maximum");
`endif

endmodule

`default_nettype wire

// ===== sv/wmm_result.sv =====
// Result stage of the window filter: mode selection, midpoint with rounding to
// nearest even, and the output register. Drops items that give no result.
// Depends on wmm_pkg.
`default_nettype none

module wmm_result (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // upstream item
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [wmm_pkg::PIX_W-1:0] lo_i,
  input  logic [wmm_pkg::PIX_W-1:0] hi_i,
  input  wmm_pkg::wmm_ctl_t         ctl_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [wmm_pkg::PIX_W-1:0] pixel_out_o,
  output logic                      frame_end_o
);
  import wmm_pkg::*;

  logic              v3_q, v3_d;
  logic [PIX_W-1:0]  lo_q, hi_q;
  logic              end_q;
  logic [MODE_W-1:0] mode_q;
  logic              out_valid_q, out_valid_d;
  logic [PIX_W-1:0]  pixel_out_q, pixel_out_d;
  logic              frame_end_q;
  logic              out_free, load3, out_load;
  logic [PIX_W:0]    sum;
  logic [PIX_W-1:0]  half, mid;

  assign out_free    = !out_valid_q || out_ready_i;
  assign ready_o     = !v3_q || out_free;
  assign load3       = valid_i && ready_o;
  assign out_load    = out_free && v3_q;
  assign v3_d        = ready_o ? (valid_i && ctl_i.emit) : v3_q;
  assign out_valid_d = out_free ? v3_q : out_valid_q;

  // Hold the window bounds of an item that gives a result
  always_ff @(posedge clk_i) begin
    if (load3) begin
      lo_q   <= lo_i;
      hi_q   <= hi_i;
      end_q  <= ctl_i.frame_end;
      mode_q <= ctl_i.mode;
    end
  end

  // Midpoint: halve the 9-bit sum, round a half up only onto an even value
  assign sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign half = sum[PIX_W:1];
  assign mid  = half + PIX_W'(sum[0] & half[0]);

  always_comb begin
    unique case (mode_q)
      MODE_MIN: pixel_out_d = lo_q;
      MODE_MAX: pixel_out_d = hi_q;
      default:  pixel_out_d = mid;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pixel_out_q <= pixel_out_d;
      frame_end_q <= end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v3_q        <= v3_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign frame_end_o = frame_end_q;

`ifndef SYNTHESIS
  // A waiting result stage keeps its bounds while the output is full
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !out_free |=> v3_q && $stable(lo_q) && $stable(hi_q))
    else $error("result stage lost a waiting item");

  // The midpoint never leaves the window bounds
  a_mid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (mode_q != MODE_MIN) && (mode_q != MODE_MAX) && (lo_q <= hi_q) |=>
      (pixel_out_q >= $past(lo_q)) && (pixel_out_q <= $past(hi_q)))
    else $error("midpoint outside the window bounds");
`endif

endmodule

`default_nettype wire

// ===== sv/window_min_max_midpoint_filter.sv =====
// Top level of the window min/max/midpoint filter: configuration registers,
// frame position counters and the pipeline. Depends on wmm_pkg, wmm_col_store,
// wmm_row_window and wmm_result.
//
// The filter takes one 8-bit pixel item per clock in raster order while the
// output is not stalled, and answers the minimum, maximum or rounded midpoint
// over a square window of side 2*radius+1, using only neighbors inside the
// frame. The host sends (height+radius) rows of (width+radius) items; items
// past the right or bottom edge are pads whose values are ignored, and the item
// at extended position (row, col) with both at least radius yields the result
// for pixel (row-radius, col-radius). The sustained rate is one item per cycle
// unless the output stalls: each item costs one byte-lane write and one column
// read of the line memory, both in the cycle it is accepted. A result reaches
// the output register through memory read, column reduction, row reduction and
// mode select. Input stays ready while the output waits as long as a pipeline
// stage is free. The line memory needs no clearing after reset. Configuration
// is written through its own port only while the filter is idle; the user must
// ensure this, the block does not enforce it, and cfg_ready_o is always high.
`default_nettype none

module window_min_max_midpoint_filter #(
  parameter int unsigned MAX_WIDTH  = wmm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_RADIUS = wmm_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wmm_pkg::PIX_W-1:0]      pixel_in_i,
  input  logic                           frame_start_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wmm_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                           frame_end_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wmm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wmm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wmm_pkg::*;

  localparam int unsigned SLOTS    = 2 * MAX_RADIUS + 1;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned RAD_W    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned COL_BITS = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
  localparam int unsigned COL_W    = (COL_BITS > FRAME_W_W) ? COL_BITS : FRAME_W_W;
  localparam int unsigned ROW_W    = FRAME_H_W;
  localparam int unsigned ADDR_W   = $clog2(MAX_WIDTH);

  // Configuration registers
  logic [FRAME_W_W-1:0] frame_width_q;
  logic [FRAME_H_W-1:0] frame_height_q;
  logic [RADIUS_W-1:0]  window_radius_q;
  logic [MODE_W-1:0]    filter_mode_q;
  logic                 cfg_fire;

  // Position counters
  logic [COL_W-1:0]  col_q, col_d, col_a, col_c, col_inc;
  logic [ROW_W-1:0]  row_q, row_d, row_a, row_b, row_c, row_inc;
  logic [SLOT_W-1:0] slot_q, slot_d, slot_a, slot_b, slot_c, slot_inc;

  // Effective frame geometry
  logic [COL_W-1:0]  width_ext, w_eff, w_m1, wext, wext_m1;
  logic [ROW_W-1:0]  h_eff, h_m1, hext, hext_m1;
  logic [RAD_W-1:0]  r_eff;

  // Per-item values for the pipeline
  logic              in_fire;
  logic              we;
  logic [SLOT_W-1:0] row_small, col_small, span;
  logic [RAD_W-1:0]  row_excess, col_excess;
  wmm_ctl_t          ctl;

  // Pipeline links
  logic              s1_valid, s1_ready;
  logic [PIX_W-1:0]  s1_vmin, s1_vmax;
  logic [SLOT_W-1:0] s1_span, s1_col_small;
  logic [RAD_W-1:0]  s1_col_excess;
  wmm_ctl_t          s1_ctl;
  logic              s2_valid, s2_ready;
  logic [PIX_W-1:0]  s2_lo, s2_hi;
  wmm_ctl_t          s2_ctl;

  function automatic logic [SLOT_W-1:0] slot_step(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    if (s == SLOT_W'(SLOTS - 1)) begin
      n = '0;
    end else begin
      n = s + SLOT_W'(1);
    end
    return n;
  endfunction

  // Take configuration writes
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= WIDTH_RST;
      frame_height_q  <= HEIGHT_RST;
      window_radius_q <= RADIUS_RST;
      filter_mode_q   <= MODE_RST;
    end else if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_WIDTH:  frame_width_q   <= cfg_data_i[FRAME_W_W-1:0];
        REG_HEIGHT: frame_height_q  <= cfg_data_i[FRAME_H_W-1:0];
        REG_RADIUS: window_radius_q <= cfg_data_i[RADIUS_W-1:0];
        REG_MODE:   filter_mode_q   <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width, height and radius into the served range
  assign width_ext = COL_W'(frame_width_q);

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = COL_W'(1);
    end else if (width_ext > COL_W'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    if (frame_height_q == '0) begin
      h_eff = ROW_W'(1);
    end else if (frame_height_q > ROW_W'(HEIGHT_LIMIT)) begin
      h_eff = ROW_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height_q;
    end
    if (32'(window_radius_q) > 32'(MAX_RADIUS)) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = RAD_W'(window_radius_q);
    end
  end

  assign w_m1    = w_eff - COL_W'(1);
  assign h_m1    = h_eff - ROW_W'(1);
  assign wext    = w_eff + COL_W'(r_eff);
  assign hext    = h_eff + ROW_W'(r_eff);
  assign wext_m1 = wext - COL_W'(1);
  assign hext_m1 = hext - ROW_W'(1);

  // Place the incoming item: frame start, then wrap a stale column or row
  always_comb begin
    col_a  = frame_start_i ? '0 : col_q;
    row_a  = frame_start_i ? '0 : row_q;
    slot_a = frame_start_i ? '0 : slot_q;
    if (col_a >= wext) begin
      col_c  = '0;
      row_b  = row_a + ROW_W'(1);
      slot_b = slot_step(slot_a);
    end else begin
      col_c  = col_a;
      row_b  = row_a;
      slot_b = slot_a;
    end
    if (row_b >= hext) begin
      row_c  = '0;
      slot_c = '0;
    end else begin
      row_c  = row_b;
      slot_c = slot_b;
    end
  end

  // Advance to the position of the next item
  always_comb begin
    col_inc  = col_c + COL_W'(1);
    row_inc  = row_c + ROW_W'(1);
    slot_inc = slot_step(slot_c);
    if (col_inc >= wext) begin
      col_d = '0;
      if (row_inc >= hext) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = row_inc;
        slot_d = slot_inc;
      end
    end else begin
      col_d  = col_inc;
      row_d  = row_c;
      slot_d = slot_c;
    end
  end

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (in_fire) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // Window limits of this item as small distances
  assign we         = (row_c < h_eff) && (col_c < w_eff);
  assign span       = SLOT_W'({r_eff, 1'b0});
  assign row_small  = (row_c < ROW_W'(SLOTS - 1)) ? SLOT_W'(row_c) : SLOT_W'(SLOTS - 1);
  assign col_small  = (col_c < COL_W'(SLOTS - 1)) ? SLOT_W'(col_c) : SLOT_W'(SLOTS - 1);
  assign row_excess = (row_c >= h_eff) ? RAD_W'(row_c - h_m1) : '0;
  assign col_excess = (col_c >= w_eff) ? RAD_W'(col_c - w_m1) : '0;

  assign ctl.emit      = (row_c >= ROW_W'(r_eff)) && (col_c >= COL_W'(r_eff));
  assign ctl.frame_end = (row_c == hext_m1) && (col_c == wext_m1);
  assign ctl.mode      = filter_mode_q;

  wmm_col_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_col_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_in_i),
    .we_i         (we),
    .addr_i       (col_c[ADDR_W-1:0]),
    .slot_i       (slot_c),
    .row_small_i  (row_small),
    .row_excess_i (row_excess),
    .span_i       (span),
    .col_small_i  (col_small),
    .col_excess_i (col_excess),
    .ctl_i        (ctl),
    .valid_o      (s1_valid),
    .dn_ready_i   (s1_ready),
    .vmin_o       (s1_vmin),
    .vmax_o       (s1_vmax),
    .span_o       (s1_span),
    .col_small_o  (s1_col_small),
    .col_excess_o (s1_col_excess),
    .ctl_o        (s1_ctl)
  );

  wmm_row_window #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_row_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid),
    .ready_o      (s1_ready),
    .vmin_i       (s1_vmin),
    .vmax_i       (s1_vmax),
    .span_i       (s1_span),
    .col_small_i  (s1_col_small),
    .col_excess_i (s1_col_excess),
    .ctl_i        (s1_ctl),
    .valid_o      (s2_valid),
    .dn_ready_i   (s2_ready),
    .lo_o         (s2_lo),
    .hi_o         (s2_hi),
    .ctl_o        (s2_ctl)
  );

  wmm_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_valid),
    .ready_o     (s2_ready),
    .lo_i        (s2_lo),
    .hi_i        (s2_hi),
    .ctl_i       (s2_ctl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .frame_end_o (frame_end_o)
  );

`ifndef SYNTHESIS
  // Row slot stays inside the line memory's lanes
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(SLOTS - 1))
    else $error("row slot out of range");

  // Row and slot counters restart together
  a_slot_tracks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q == '0 |-> slot_q == '0)
    else $error("row slot out of step with the row counter");
`endif

endmodule

`default_nettype wire
